>>> rtl/core/assert_macros.svh
// Assertion helpers for the rotation core.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AAVR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant, checked at every edge outside reset.
`define AAVR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

>>> rtl/core/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and arithmetic helpers for the axis-angle rotation
// core: angle constants, CORDIC arctangent table, Q.30 product.
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

	localparam int FRAC_BITS_DEF     = 30;
	localparam int CORDIC_STAGES_DEF = 28;

	// Internal work format is Q.30
	localparam int WB = 30;
	// CORDIC datapath width and general work width
	localparam int CW = 34;
	localparam int WW = 36;

	localparam int DEG90  = 5898240;
	localparam int DEG180 = 11796480;
	localparam int DEG360 = 23592960;

	// Degree-to-radian scale, split for two narrow multipliers
	localparam longint RAD_K  = 64'sd19190098069;
	localparam int     K_SPLIT = 18;
	localparam longint RAD_KHI = RAD_K >>> K_SPLIT;
	localparam longint RAD_KLO = RAD_K - (RAD_KHI <<< K_SPLIT);

	localparam int CORDIC_GAIN = 652032874;
	// Largest reduced angle in Q.30 radians (a quarter turn, rounded up)
	localparam longint Z_MAX = 64'sd1686629714;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [WW-1:0] work_t;

	// Operands that ride along with the angle path
	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic               neg;
	} carry_t;

	// atan(2^-i) in Q.30 radians
	function automatic cval_t atan_of(int i);
		cval_t r;
		case (i)
			0:       r = CW'(843314857);
			1:       r = CW'(497837829);
			2:       r = CW'(263043837);
			3:       r = CW'(133525159);
			4:       r = CW'(67021687);
			5:       r = CW'(33543516);
			6:       r = CW'(16775851);
			7:       r = CW'(8388437);
			8:       r = CW'(4194283);
			9:       r = CW'(2097149);
			10:      r = CW'(1048576);
			11:      r = CW'(524288);
			default: r = (i <= WB) ? (cval_t'(1) <<< (WB - i)) : '0;
		endcase
		return r;
	endfunction

	// Q.30 product, rounded half up
	function automatic work_t mulq(work_t a, work_t b);
		logic signed [2*WW-1:0] p;
		p = a * b + (2*WW)'(64'sd1 <<< (WB - 1));
		p = p >>> WB;
		return p[WW-1:0];
	endfunction

	// Clamp a component to plus or minus one and bring it to Q.30
	function automatic logic signed [31:0] to_work(logic signed [31:0] raw, int frac);
		longint v;
		longint one;
		one = 64'sd1 <<< frac;
		v = longint'(raw);
		if (v > one) v = one;
		if (v < -one) v = -one;
		if (frac >= WB) v = v >>> (frac - WB);
		else v = v <<< (WB - frac);
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/axis_angle_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_core
// Rotates a vector about a unit axis by an angle in degrees: angle reduction,
// pipelined CORDIC for cosine and sine, Rodrigues matrix, matrix-vector product.
// ----------------------------------------------------------------------------
//  channel  | handshake     | payload
//  request  | start / busy  | axis_x/y/z, vec_x/y/z, angle_deg
//  result   | done          | rot_x, rot_y, rot_z
//
// One request per cycle; busy stays low since the pipeline never fills up.
// The pipeline has five angle stages, one CORDIC stage per iteration and six
// matrix stages ending in the output register.
// Reset clears only the valid bits; payload registers hold no reset value.
// The receiver cannot stall, so results leave on done without back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module axis_angle_vector_rotate_core #(
	parameter int FRAC_BITS     = aavr_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = aavr_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] axis_x,
	input  wire logic signed [31:0] axis_y,
	input  wire logic signed [31:0] axis_z,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [25:0] angle_deg,
	output logic                    done,
	output logic signed [31:0]      rot_x,
	output logic signed [31:0]      rot_y,
	output logic signed [31:0]      rot_z
);
	import aavr_pkg::*;

	localparam int LAT = 11 + CORDIC_STAGES;
	localparam longint OUT_HI = (FRAC_BITS >= 31) ? 64'sd2147483647 : (64'sd1 <<< FRAC_BITS);
	localparam longint OUT_LO = (FRAC_BITS >= 31) ? -64'sd2147483648 : -(64'sd1 <<< FRAC_BITS);

	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Angle path stages s1..s5
	// ------------------------------------------------------------------
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	carry_t                 car_s1, car_s2, car_s3, car_s4, car_s5;
	logic signed [26:0]     ang_s1, ang_s2;
	logic signed [23:0]     ang_s3;
	logic signed [41:0]     phi_s4;
	logic signed [42:0]     plo_s4;
	cval_t                  z_s5;

	logic signed [26:0]     ang_red;
	logic signed [26:0]     ang_fold;
	logic                   neg_fold;
	carry_t                 car_fold;
	logic signed [60:0]     z_full;

	// Reduce modulo a full turn, then wrap into the half-open range of plus or minus a half turn
	always_comb begin
		ang_red = ang_s1;
		if (ang_s1 >= 27'(DEG360)) ang_red = ang_s1 - 27'(DEG360);
		else if (ang_s1 <= -27'(DEG360)) ang_red = ang_s1 + 27'(DEG360);
		if (ang_red >= 27'(DEG180)) ang_red = ang_red - 27'(DEG360);
		if (ang_red < -27'(DEG180)) ang_red = ang_red + 27'(DEG360);
	end

	// Fold past a quarter turn and flag the cosine sign
	always_comb begin
		ang_fold = ang_s2;
		neg_fold = 1'b0;
		if (ang_s2 > 27'(DEG90)) begin
			ang_fold = 27'(DEG180) - ang_s2;
			neg_fold = 1'b1;
		end else if (ang_s2 < -27'(DEG90)) begin
			ang_fold = -27'(DEG180) - ang_s2;
			neg_fold = 1'b1;
		end
		car_fold     = car_s2;
		car_fold.neg = neg_fold;
	end

	// Recombine the split radian product and round
	always_comb begin
		z_full = (61'(phi_s4) <<< K_SPLIT) + 61'(plo_s4) + (61'sd1 <<< 25);
		z_full = z_full >>> 26;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// clamp and convert operands
		car_s1.ux  <= to_work(axis_x, FRAC_BITS);
		car_s1.uy  <= to_work(axis_y, FRAC_BITS);
		car_s1.uz  <= to_work(axis_z, FRAC_BITS);
		car_s1.vx  <= to_work(vec_x, FRAC_BITS);
		car_s1.vy  <= to_work(vec_y, FRAC_BITS);
		car_s1.vz  <= to_work(vec_z, FRAC_BITS);
		car_s1.neg <= 1'b0;
		ang_s1     <= 27'(angle_deg);
		// reduce
		car_s2     <= car_s1;
		ang_s2     <= ang_red;
		// fold
		car_s3     <= car_fold;
		ang_s3     <= ang_fold[23:0];
		// scale to radians
		car_s4     <= car_s3;
		phi_s4     <= ang_s3 * $signed({1'b0, RAD_KHI[16:0]});
		plo_s4     <= ang_s3 * $signed({1'b0, RAD_KLO[17:0]});
		car_s5     <= car_s4;
		z_s5       <= z_full[CW-1:0];
	end

	// ------------------------------------------------------------------
	// CORDIC, one iteration per stage
	// ------------------------------------------------------------------
	logic   vld_sc [0:CORDIC_STAGES];
	carry_t car_sc [0:CORDIC_STAGES];
	cval_t  x_sc   [0:CORDIC_STAGES];
	cval_t  y_sc   [0:CORDIC_STAGES];
	cval_t  z_sc   [0:CORDIC_STAGES];

	// Feed the first iteration from the angle path
	always_comb begin
		vld_sc[0] = vld_s5;
		car_sc[0] = car_s5;
		x_sc[0]   = cval_t'(CORDIC_GAIN);
		y_sc[0]   = '0;
		z_sc[0]   = z_s5;
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		cval_t dx, dy, da;
		assign dx = y_sc[k] >>> k;
		assign dy = x_sc[k] >>> k;
		assign da = atan_of(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sc[k+1] <= 1'b0;
			else vld_sc[k+1] <= vld_sc[k];
		end

		// advance one micro-rotation toward zero residual angle
		always_ff @(posedge clk) begin
			car_sc[k+1] <= car_sc[k];
			if (z_sc[k] >= 0) begin
				x_sc[k+1] <= x_sc[k] - dx;
				y_sc[k+1] <= y_sc[k] + dy;
				z_sc[k+1] <= z_sc[k] - da;
			end else begin
				x_sc[k+1] <= x_sc[k] + dx;
				y_sc[k+1] <= y_sc[k] - dy;
				z_sc[k+1] <= z_sc[k] + da;
			end
		end
	end

	// ------------------------------------------------------------------
	// Matrix stages s6..s11
	// ------------------------------------------------------------------
	logic   vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	carry_t car_s6, car_s7, car_s8, car_s9;
	work_t  c_s6, s_s6, omc_s6;
	work_t  c_s7, omc_s7;
	work_t  pxx_s7, pyy_s7, pzz_s7, pxy_s7, pxz_s7, pyz_s7;
	work_t  sx_s7, sy_s7, sz_s7;
	work_t  c_s8, sx_s8, sy_s8, sz_s8;
	work_t  qxx_s8, qyy_s8, qzz_s8, qxy_s8, qxz_s8, qyz_s8;
	work_t  m00_s9, m01_s9, m02_s9, m10_s9, m11_s9, m12_s9, m20_s9, m21_s9, m22_s9;
	work_t  t00_s10, t01_s10, t02_s10, t10_s10, t11_s10, t12_s10;
	work_t  t20_s10, t21_s10, t22_s10;

	work_t  cx_end;
	carry_t car_end;
	assign car_end = car_sc[CORDIC_STAGES];
	assign cx_end  = WW'(x_sc[CORDIC_STAGES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s6  <= vld_sc[CORDIC_STAGES];
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Saturate one component and bring it back to the output format
	function automatic logic signed [31:0] from_work(work_t t0, work_t t1, work_t t2);
		longint r;
		r = longint'(t0) + longint'(t1) + longint'(t2);
		if (r > (64'sd1 <<< WB)) r = 64'sd1 <<< WB;
		if (r < -(64'sd1 <<< WB)) r = -(64'sd1 <<< WB);
		if (FRAC_BITS >= WB) r = r <<< (FRAC_BITS - WB);
		else r = r >>> (WB - FRAC_BITS);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		// cosine, sine, one minus cosine
		car_s6 <= car_end;
		c_s6   <= car_end.neg ? -cx_end : cx_end;
		s_s6   <= WW'(y_sc[CORDIC_STAGES]);
		omc_s6 <= (work_t'(1) <<< WB) - (car_end.neg ? -cx_end : cx_end);
		// axis products and sine terms
		car_s7 <= car_s6;
		c_s7   <= c_s6;
		omc_s7 <= omc_s6;
		pxx_s7 <= mulq(WW'(car_s6.ux), WW'(car_s6.ux));
		pyy_s7 <= mulq(WW'(car_s6.uy), WW'(car_s6.uy));
		pzz_s7 <= mulq(WW'(car_s6.uz), WW'(car_s6.uz));
		pxy_s7 <= mulq(WW'(car_s6.ux), WW'(car_s6.uy));
		pxz_s7 <= mulq(WW'(car_s6.ux), WW'(car_s6.uz));
		pyz_s7 <= mulq(WW'(car_s6.uy), WW'(car_s6.uz));
		sx_s7  <= mulq(WW'(car_s6.ux), s_s6);
		sy_s7  <= mulq(WW'(car_s6.uy), s_s6);
		sz_s7  <= mulq(WW'(car_s6.uz), s_s6);
		// scale by one minus cosine
		car_s8 <= car_s7;
		c_s8   <= c_s7;
		sx_s8  <= sx_s7;
		sy_s8  <= sy_s7;
		sz_s8  <= sz_s7;
		qxx_s8 <= mulq(pxx_s7, omc_s7);
		qyy_s8 <= mulq(pyy_s7, omc_s7);
		qzz_s8 <= mulq(pzz_s7, omc_s7);
		qxy_s8 <= mulq(pxy_s7, omc_s7);
		qxz_s8 <= mulq(pxz_s7, omc_s7);
		qyz_s8 <= mulq(pyz_s7, omc_s7);
		// assemble the rotation matrix
		car_s9 <= car_s8;
		m00_s9 <= c_s8 + qxx_s8;
		m01_s9 <= qxy_s8 - sz_s8;
		m02_s9 <= qxz_s8 + sy_s8;
		m10_s9 <= qxy_s8 + sz_s8;
		m11_s9 <= c_s8 + qyy_s8;
		m12_s9 <= qyz_s8 - sx_s8;
		m20_s9 <= qxz_s8 - sy_s8;
		m21_s9 <= qyz_s8 + sx_s8;
		m22_s9 <= c_s8 + qzz_s8;
		// matrix times vector
		t00_s10 <= mulq(m00_s9, WW'(car_s9.vx));
		t01_s10 <= mulq(m01_s9, WW'(car_s9.vy));
		t02_s10 <= mulq(m02_s9, WW'(car_s9.vz));
		t10_s10 <= mulq(m10_s9, WW'(car_s9.vx));
		t11_s10 <= mulq(m11_s9, WW'(car_s9.vy));
		t12_s10 <= mulq(m12_s9, WW'(car_s9.vz));
		t20_s10 <= mulq(m20_s9, WW'(car_s9.vx));
		t21_s10 <= mulq(m21_s9, WW'(car_s9.vy));
		t22_s10 <= mulq(m22_s9, WW'(car_s9.vz));
		// sum and saturate into the output register
		rot_x <= from_work(t00_s10, t01_s10, t02_s10);
		rot_y <= from_work(t10_s10, t11_s10, t12_s10);
		rot_z <= from_work(t20_s10, t21_s10, t22_s10);
	end

	assign done = vld_s11;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`AAVR_ASSERT_IMP(a_done_latency, done, $past(start, LAT), "result without a request")
	`AAVR_ASSERT_IMP(a_z_range, vld_s5, (longint'(z_s5) <= Z_MAX) && (longint'(z_s5) >= -Z_MAX), "reduced angle out of range")
	`AAVR_ASSERT_IMP(a_out_range, done, (longint'(rot_x) <= OUT_HI) && (longint'(rot_x) >= OUT_LO) && (longint'(rot_y) <= OUT_HI) && (longint'(rot_y) >= OUT_LO) && (longint'(rot_z) <= OUT_HI) && (longint'(rot_z) >= OUT_LO), "result not saturated")

endmodule

`default_nettype wire

>>> tb/tb_axis_angle_vector_rotate_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotate_core
// Drives directed and random-burst rotation requests, predicts each rotated vector with
// a bit-exact model of the angle reduction, CORDIC and Rodrigues matrix, and
// checks every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_axis_angle_vector_rotate_core;
	import aavr_pkg::*;

	localparam longint ONE_Q   = 64'sd1 <<< 30;
	localparam int     WDOG_MAX = 2000;

	typedef struct {
		logic signed [31:0] ux, uy, uz, vx, vy, vz;
		logic signed [25:0] ang;
	} rot_req_t;

	typedef struct {
		logic signed [31:0] x, y, z;
	} rot_vec_t;

	// Predicts rotated vectors and checks them in order
	class rotation_scoreboard;
		rot_vec_t pending[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		static function longint shr(longint v, int s);
			return v >>> s;
		endfunction

		static function longint qmul(longint a, longint b);
			return (a * b + (64'sd1 <<< 29)) >>> 30;
		endfunction

		static function longint clip(logic signed [31:0] raw);
			longint v;
			v = raw;
			if (v > ONE_Q) v = ONE_Q;
			if (v < -ONE_Q) v = -ONE_Q;
			return v;
		endfunction

		static function longint atan_q(int i);
			longint tab[12] = '{843314857, 497837829, 263043837, 133525159, 67021687,
				33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288};
			if (i < 12) return tab[i];
			if (i <= 30) return 64'sd1 <<< (30 - i);
			return 0;
		endfunction

		static function logic signed [31:0] sat(longint r);
			if (r > ONE_Q) r = ONE_Q;
			if (r < -ONE_Q) r = -ONE_Q;
			if (r > 2147483647) r = 2147483647;
			return r[31:0];
		endfunction

		function void note_request(rot_req_t q);
			longint ux, uy, uz, vx, vy, vz, a, x, y, z, dx, dy, c, s, omc;
			longint m[3][3];
			longint u[3];
			longint v[3];
			longint r[3];
			bit neg;
			rot_vec_t e;
			ux = clip(q.ux); uy = clip(q.uy); uz = clip(q.uz);
			vx = clip(q.vx); vy = clip(q.vy); vz = clip(q.vz);
			a = q.ang;
			neg = 0;
			// reduce the angle exactly in degree units (C-style remainder)
			a = a - (a / DEG360) * DEG360;
			if (a >= DEG180) a -= DEG360;
			if (a < -DEG180) a += DEG360;
			if (a > DEG90) begin
				a = DEG180 - a; neg = 1;
			end else if (a < -DEG90) begin
				a = -DEG180 - a; neg = 1;
			end
			z = (a * RAD_K + (64'sd1 <<< 25)) >>> 26;
			x = CORDIC_GAIN;
			y = 0;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = shr(y, i);
				dy = shr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_q(i);
				end else begin
					x += dx; y -= dy; z += atan_q(i);
				end
			end
			c = neg ? -x : x;
			s = y;
			omc = ONE_Q - c;
			u[0] = ux; u[1] = uy; u[2] = uz;
			v[0] = vx; v[1] = vy; v[2] = vz;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m[i][j] = qmul(qmul(u[i], u[j]), omc) + ((i == j) ? c : 0);
			m[0][1] -= qmul(uz, s); m[0][2] += qmul(uy, s);
			m[1][0] += qmul(uz, s); m[1][2] -= qmul(ux, s);
			m[2][0] -= qmul(uy, s); m[2][1] += qmul(ux, s);
			for (int i = 0; i < 3; i++)
				r[i] = qmul(m[i][0], v[0]) + qmul(m[i][1], v[1]) + qmul(m[i][2], v[2]);
			e.x = sat(r[0]); e.y = sat(r[1]); e.z = sat(r[2]);
			pending.push_back(e);
		endfunction

		function void check_result(logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z);
			rot_vec_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %0d %0d %0d", x, y, z);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$error("rot_x expected %0d actual %0d", e.x, x); errors++;
			end
			if (y !== e.y) begin
				$error("rot_y expected %0d actual %0d", e.y, y); errors++;
			end
			if (z !== e.z) begin
				$error("rot_z expected %0d actual %0d", e.z, z); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic signed [31:0] axis_x = 0, axis_y = 0, axis_z = 0;
	logic signed [31:0] vec_x = 0, vec_y = 0, vec_z = 0;
	logic signed [25:0] angle_deg = 0;
	logic signed [31:0] rot_x, rot_y, rot_z;

	rotation_scoreboard sb = new();
	rot_req_t held;
	int  idle_cycles = 0;
	bit  timed_out = 0;

	axis_angle_vector_rotate_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .angle_deg(angle_deg),
		.done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	always #2 clk = ~clk;

	// Note accepted requests, check results, run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_request(held);
			if (done) sb.check_result(rot_x, rot_y, rot_z);
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > WDOG_MAX) begin
				timed_out = 1;
				$display("tb_axis_angle_vector_rotate_core: FAIL");
				$finish;
			end
		end
	end

	// Component with full-range random bits, mostly inside plus or minus one
	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return ONE_Q;
			2: return -ONE_Q;
			default: return $signed($urandom_range(0, 2 * 32'h4000_0000)) - ONE_Q;
		endcase
	endfunction

	function automatic logic signed [25:0] rand_angle();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 2 * DEG360)) - DEG360;
	endfunction

	// Present one request and hold it until accepted
	task automatic send_request(rot_req_t q);
		held = q;
		axis_x = q.ux; axis_y = q.uy; axis_z = q.uz;
		vec_x = q.vx; vec_y = q.vy; vec_z = q.vz; angle_deg = q.ang;
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_mixed(rot_req_t q, bit last_in_burst);
		send_request(q);
		if (last_in_burst) start = 0;
	endtask

	function automatic rot_req_t make_req(longint ux, longint uy, longint uz,
			longint vx, longint vy, longint vz, longint ang);
		rot_req_t q;
		q.ux = ux; q.uy = uy; q.uz = uz; q.vx = vx; q.vy = vy; q.vz = vz; q.ang = ang;
		return q;
	endfunction

	initial begin
		rot_req_t q;
		int burst;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: quadrants, wrap, fold, clamps, non-unit axis, field extremes
		send_mixed(make_req(0, 0, ONE_Q, ONE_Q, 0, 0, 0), 0);
		send_mixed(make_req(0, 0, ONE_Q, ONE_Q, 0, 0, DEG90), 0);
		send_mixed(make_req(0, 0, ONE_Q, ONE_Q, 0, 0, -DEG90), 0);
		send_mixed(make_req(0, 0, ONE_Q, ONE_Q, 0, 0, DEG180), 0);
		send_mixed(make_req(0, 0, ONE_Q, ONE_Q, 0, 0, -DEG180), 0);
		send_mixed(make_req(ONE_Q, 0, 0, 0, ONE_Q, 0, DEG360), 0);
		send_mixed(make_req(ONE_Q, 0, 0, 0, ONE_Q, 0, -DEG360), 1);
		send_mixed(make_req(0, ONE_Q, 0, 0, 0, ONE_Q, DEG90 + 12345), 0);
		send_mixed(make_req(0, ONE_Q, 0, 0, 0, -ONE_Q, -DEG90 - 777), 0);
		send_mixed(make_req(0, -ONE_Q, 0, ONE_Q, 0, 0, 26'sh1FFFFFF), 0);
		send_mixed(make_req(0, 0, -ONE_Q, ONE_Q, ONE_Q, ONE_Q, -26'sh2000000), 0);
		send_mixed(make_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			-32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000, 1), 1);
		send_mixed(make_req(ONE_Q, ONE_Q, ONE_Q, ONE_Q, -ONE_Q, ONE_Q, DEG90 / 2), 0);
		send_mixed(make_req(-32'sd1, 32'sd1, 0, -32'sd1, 32'sd1, 0, -1), 0);
		send_mixed(make_req(ONE_Q / 2, ONE_Q / 3, 0, ONE_Q, ONE_Q, 0, DEG180 - 1), 1);

		// random bursts with random gaps
		for (int n = 0; n < 400; ) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++, n++) begin
				q = make_req(rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), rand_comp(), rand_comp(), rand_angle());
				send_mixed(q, k == burst - 1);
			end
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 50)) @(negedge clk);
		end
		start = 0;

		while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
		repeat (60) @(posedge clk);
		if (timed_out) begin
			$display("tb_axis_angle_vector_rotate_core: FAIL");
		end else if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_axis_angle_vector_rotate_core: PASS");
		end else begin
			$display("tb_axis_angle_vector_rotate_core: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
